// ----- sv/rsje_pkg.sv -----
// rsje_pkg: shared types, constants and result builder for the record stream
// jpeg extractor; no dependencies
package rsje_pkg;

  localparam logic [31:0] JPEG_TYPE  = 32'ha04a709a;
  localparam logic [31:0] HDR_BYTES  = 32'd20;
  localparam logic [4:0]  HDR_LAST   = 5'd19;
  localparam logic [7:0]  SYNC_BYTE  = 8'ha0;
  localparam logic [7:0]  SOI_HI     = 8'hff;
  localparam logic [7:0]  SOI_LO     = 8'hd8;
  localparam logic [4:0]  SCAN_LIMIT = 5'd16;
  localparam logic [31:0] TRL_LAST   = 32'd3;
  localparam int          OQ_DEPTH   = 4;
  localparam int          OQ_AW      = $clog2(OQ_DEPTH);

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_PAYLOAD = 4'b0010,
    PH_TRAILER = 4'b0100,
    PH_SCAN    = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_STREAM = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNC_PAY = 3'd1,
    ST_TRUNC_HDR = 3'd2,
    ST_TRUNC_TRL = 3'd3,
    ST_BAD_REF   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic {
    CFG_MATCH_ENABLE = 1'b0,
    CFG_MATCH_TIME   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [63:0] stamp;
    logic        frame_start;
    logic [2:0]  status;
    logic        last;
  } result_t;

  // number of results one request produces
  typedef logic [1:0] push_cnt_t;

  function automatic result_t mk_res(kind_t k, logic [7:0] d, logic [63:0] s,
                                     logic fs, status_t st);
    result_t r;
    r.kind        = k;
    r.data        = d;
    r.stamp       = s;
    r.frame_start = fs;
    r.status      = st;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

// ----- sv/rsje_core.sv -----
// rsje_core: record parser state and per-request result generation
// depends on rsje_pkg
module rsje_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic                cmd,
  input  logic [7:0]          byte_in,
  input  logic                match_enable,
  input  logic [63:0]         match_timestamp,
  output rsje_pkg::push_cnt_t push_cnt,
  output rsje_pkg::result_t   res0,
  output rsje_pkg::result_t   res1
);
  import rsje_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] byte_count_r, byte_count_nxt;
  logic [31:0] rec_type_r, rec_type_nxt;
  logic [63:0] rec_time_r, rec_time_nxt;
  logic [31:0] rec_length_r, rec_length_nxt;
  logic [31:0] trailer_shift_r, trailer_shift_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        frame_wanted_r, frame_wanted_nxt;
  logic [4:0]  scan_left_r, scan_left_nxt;
  logic        stopped_r, stopped_nxt;

  logic        do_hdr;
  logic [4:0]  hdr_idx;
  logic [31:0] bc_inc;
  logic [31:0] trl_v;
  logic [31:0] expect_len;
  logic [4:0]  scan_dec;
  push_cnt_t   n;
  result_t     r0, r1;

  always_comb begin
    phase_nxt         = phase_r;
    byte_count_nxt    = byte_count_r;
    rec_type_nxt      = rec_type_r;
    rec_time_nxt      = rec_time_r;
    rec_length_nxt    = rec_length_r;
    trailer_shift_nxt = trailer_shift_r;
    held_byte_nxt     = held_byte_r;
    frame_wanted_nxt  = frame_wanted_r;
    scan_left_nxt     = scan_left_r;
    stopped_nxt       = stopped_r;
    do_hdr            = 1'b0;
    hdr_idx           = byte_count_r[4:0];
    bc_inc            = byte_count_r + 32'd1;
    trl_v             = {trailer_shift_r[23:0], byte_in};
    expect_len        = HDR_BYTES + rec_length_r;
    scan_dec          = (scan_left_r != 5'd0) ? scan_left_r - 5'd1 : 5'd0;
    n                 = 2'd0;
    r0                = '0;
    r1                = '0;

    if (acc && !stopped_r) begin
      if (cmd) begin
        stopped_nxt = 1'b1;
        case (phase_r)
          PH_HEADER: begin
            n  = 2'd1;
            r0 = mk_res(KIND_STREAM, 8'd0, 64'd0, 1'b0,
                        (byte_count_r != 32'd0) ? ST_TRUNC_HDR :
                        (match_enable ? ST_NOT_FOUND : ST_OK));
          end
          PH_PAYLOAD: begin
            if (frame_wanted_r && byte_count_r >= 32'd2) begin
              n  = 2'd2;
              r0 = mk_res(KIND_FRAME, 8'd0, rec_time_r, 1'b0, ST_TRUNC_PAY);
              r1 = mk_res(KIND_STREAM, 8'd0, 64'd0, 1'b0,
                          match_enable ? ST_NOT_FOUND : ST_TRUNC_PAY);
            end else begin
              n  = 2'd1;
              r0 = mk_res(KIND_STREAM, 8'd0, 64'd0, 1'b0,
                          match_enable ? ST_NOT_FOUND : ST_TRUNC_PAY);
            end
          end
          PH_TRAILER: begin
            if (frame_wanted_r) begin
              n  = 2'd2;
              r0 = mk_res(KIND_FRAME, 8'd0, rec_time_r, 1'b0, ST_TRUNC_TRL);
              r1 = mk_res(KIND_STREAM, 8'd0, 64'd0, 1'b0, ST_TRUNC_TRL);
            end else begin
              n  = 2'd1;
              r0 = mk_res(KIND_STREAM, 8'd0, 64'd0, 1'b0, ST_TRUNC_TRL);
            end
          end
          default: begin
            n  = 2'd1;
            r0 = mk_res(KIND_STREAM, 8'd0, 64'd0, 1'b0,
                        match_enable ? ST_NOT_FOUND : ST_OK);
          end
        endcase
      end else begin
        case (phase_r)
          PH_SCAN: begin
            if (byte_in == SYNC_BYTE) begin
              do_hdr  = 1'b1;
              hdr_idx = 5'd0;
            end else begin
              scan_left_nxt  = scan_dec;
              byte_count_nxt = 32'd0;
              if (scan_dec == 5'd0) begin
                phase_nxt = PH_HEADER;
              end
            end
          end
          PH_HEADER: begin
            do_hdr = 1'b1;
          end
          PH_PAYLOAD: begin
            if (frame_wanted_r) begin
              if (byte_count_r == 32'd0) begin
                held_byte_nxt = byte_in;
              end else if (byte_count_r == 32'd1) begin
                if (held_byte_r == SOI_HI && byte_in == SOI_LO) begin
                  n  = 2'd2;
                  r0 = mk_res(KIND_BYTE, held_byte_r, rec_time_r, 1'b1, ST_OK);
                  r1 = mk_res(KIND_BYTE, byte_in, rec_time_r, 1'b0, ST_OK);
                end else begin
                  frame_wanted_nxt = 1'b0;
                end
              end else begin
                n  = 2'd1;
                r0 = mk_res(KIND_BYTE, byte_in, rec_time_r, 1'b0, ST_OK);
              end
            end
            if (bc_inc >= rec_length_r) begin
              if (rec_length_r < 32'd2) begin
                frame_wanted_nxt = 1'b0;
              end
              byte_count_nxt    = 32'd0;
              trailer_shift_nxt = 32'd0;
              phase_nxt         = PH_TRAILER;
            end else begin
              byte_count_nxt = bc_inc;
            end
          end
          PH_TRAILER: begin
            if (byte_count_r == TRL_LAST) begin
              byte_count_nxt    = 32'd0;
              trailer_shift_nxt = trl_v;
              frame_wanted_nxt  = 1'b0;
              if (trl_v == expect_len || trl_v == 32'd0) begin
                if (frame_wanted_r) begin
                  n  = 2'd1;
                  r0 = mk_res(KIND_FRAME, 8'd0, rec_time_r, 1'b0, ST_OK);
                end
                if (frame_wanted_r && match_enable) begin
                  n           = 2'd2;
                  r1          = mk_res(KIND_STREAM, 8'd0, 64'd0, 1'b0, ST_OK);
                  stopped_nxt = 1'b1;
                end else if (trl_v == expect_len) begin
                  phase_nxt = PH_HEADER;
                end else begin
                  phase_nxt     = PH_SCAN;
                  scan_left_nxt = SCAN_LIMIT;
                end
              end else begin
                stopped_nxt = 1'b1;
                if (frame_wanted_r) begin
                  n  = 2'd2;
                  r0 = mk_res(KIND_FRAME, 8'd0, rec_time_r, 1'b0, ST_BAD_REF);
                  r1 = mk_res(KIND_STREAM, 8'd0, 64'd0, 1'b0, ST_BAD_REF);
                end else begin
                  n  = 2'd1;
                  r0 = mk_res(KIND_STREAM, 8'd0, 64'd0, 1'b0, ST_BAD_REF);
                end
              end
            end else begin
              byte_count_nxt    = bc_inc;
              trailer_shift_nxt = trl_v;
            end
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase

        // header byte capture, shared by header phase and scan hit
        if (do_hdr) begin
          phase_nxt = PH_HEADER;
          if (hdr_idx < 5'd4) begin
            rec_type_nxt = {rec_type_r[23:0], byte_in};
          end else if (hdr_idx >= 5'd8 && hdr_idx < 5'd16) begin
            rec_time_nxt = {rec_time_r[55:0], byte_in};
          end else if (hdr_idx >= 5'd16) begin
            rec_length_nxt = {rec_length_r[23:0], byte_in};
          end
          byte_count_nxt = {27'd0, hdr_idx + 5'd1};
          if (hdr_idx == HDR_LAST) begin
            byte_count_nxt    = 32'd0;
            trailer_shift_nxt = 32'd0;
            frame_wanted_nxt  = (rec_type_nxt == JPEG_TYPE) &&
                                (!match_enable || rec_time_nxt == match_timestamp);
            if (rec_length_nxt == 32'd0) begin
              frame_wanted_nxt = 1'b0;
              phase_nxt        = PH_TRAILER;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
      end
    end

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end else if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEADER;
      byte_count_r    <= '0;
      rec_type_r      <= '0;
      rec_time_r      <= '0;
      rec_length_r    <= '0;
      trailer_shift_r <= '0;
      held_byte_r     <= '0;
      frame_wanted_r  <= 1'b0;
      scan_left_r     <= '0;
      stopped_r       <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      byte_count_r    <= byte_count_nxt;
      rec_type_r      <= rec_type_nxt;
      rec_time_r      <= rec_time_nxt;
      rec_length_r    <= rec_length_nxt;
      trailer_shift_r <= trailer_shift_nxt;
      held_byte_r     <= held_byte_nxt;
      frame_wanted_r  <= frame_wanted_nxt;
      scan_left_r     <= scan_left_nxt;
      stopped_r       <= stopped_nxt;
    end
  end

  assign push_cnt = n;
  assign res0     = r0;
  assign res1     = r1;

endmodule

// ----- sv/rsje_outq.sv -----
// rsje_outq: small result queue, takes up to two results per cycle
// depends on rsje_pkg
module rsje_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  rsje_pkg::push_cnt_t push_cnt,
  input  rsje_pkg::result_t   d0,
  input  rsje_pkg::result_t   d1,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output rsje_pkg::result_t   q
);
  import rsje_pkg::*;

  result_t          mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] head_r, head_nxt;
  logic [OQ_AW-1:0] tail_r, tail_nxt;
  logic [OQ_AW:0]   count_r, count_nxt;
  logic             pop;
  logic [OQ_AW-1:0] tail_p1;

  assign pop       = (count_r != '0) && !out_stall;
  assign tail_p1   = tail_r + OQ_AW'(1);
  assign head_nxt  = pop ? head_r + OQ_AW'(1) : head_r;
  assign tail_nxt  = tail_r + OQ_AW'(push_cnt);
  assign count_nxt = count_r + (OQ_AW + 1)'(push_cnt) - (OQ_AW + 1)'(pop);

  // two free entries needed for a worst-case request
  assign room      = count_r <= (OQ_AW + 1)'(OQ_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign q         = mem_r[head_r];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[tail_r] <= d0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[tail_p1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- sv/record_stream_jpeg_extractor.sv -----
// record_stream_jpeg_extractor: top level, config registers, parser and result queue
// depends on rsje_pkg, rsje_core, rsje_outq
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_cmd, in_byte_in
//   out_     output     out_valid / out_stall kind, data, stamp, frame_start, status, last
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one request per cycle while in_stall is low; its results enter a four-entry queue in the same edge
// a request giving two results leaves the queue as two separate output transfers, so the queue sets the rate then
// in_stall is high while fewer than two queue entries are free
// synchronous active-low reset clears parser state, config and queue pointers
// cfg_ready is always high
module record_stream_jpeg_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data,
  output logic [63:0] out_stamp,
  output logic        out_frame_start,
  output logic [2:0]  out_status,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import rsje_pkg::*;

  logic        match_enable_r, match_enable_nxt;
  logic [63:0] match_timestamp_r, match_timestamp_nxt;
  logic        room;
  logic        acc;
  push_cnt_t   push_cnt;
  result_t     res0, res1, q;

  assign cfg_ready = 1'b1;
  assign in_stall  = !room;
  assign acc       = in_valid && room;

  always_comb begin
    match_enable_nxt    = match_enable_r;
    match_timestamp_nxt = match_timestamp_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MATCH_ENABLE: match_enable_nxt    = cfg_data[0];
        CFG_MATCH_TIME:   match_timestamp_nxt = cfg_data;
        default: begin
          match_enable_nxt = match_enable_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_enable_r    <= 1'b0;
      match_timestamp_r <= '0;
    end else begin
      match_enable_r    <= match_enable_nxt;
      match_timestamp_r <= match_timestamp_nxt;
    end
  end

  rsje_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .acc             (acc),
    .cmd             (in_cmd),
    .byte_in         (in_byte_in),
    .match_enable    (match_enable_r),
    .match_timestamp (match_timestamp_r),
    .push_cnt        (push_cnt),
    .res0            (res0),
    .res1            (res1)
  );

  rsje_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .d0        (res0),
    .d1        (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .q         (q)
  );

  assign out_kind        = q.kind;
  assign out_data        = q.data;
  assign out_stamp       = q.stamp;
  assign out_frame_start = q.frame_start;
  assign out_status      = q.status;
  assign out_last        = q.last;

endmodule
